// ----- rtl/core/sfs_pkg.sv -----
// Package: shared constants, stage payload types and a helper function for the subtractor.
`timescale 1ns / 1ps
package sfs_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned ExpW = 8;
	localparam int unsigned FracW = 23;
	localparam int unsigned MantW = FracW + 1;
	localparam int unsigned LzW = 5;
	localparam logic [ExpW-1:0] ExpMax = 8'hFF;

	// Stage 1 -> 2: aligned operands
	typedef struct packed {
		logic             bypass;
		logic [WordW-1:0] bypass_word;
		logic             sa;
		logic             sb;
		logic             add_op;
		logic [ExpW-1:0]  er;
		logic [MantW-1:0] ma;
		logic [MantW-1:0] mb;
	} align_t;

	// Stage 2 -> 3: raw magnitude result
	typedef struct packed {
		logic             bypass;
		logic [WordW-1:0] bypass_word;
		logic             sr;
		logic             add_op;
		logic [ExpW-1:0]  er;
		logic [MantW:0]   mr;
	} sum_t;

	// Width of one pipeline register: fits the wider stage payload
	localparam int unsigned PipeW = $bits(align_t) > $bits(sum_t) ?
		$bits(align_t) : $bits(sum_t);

	// Leading zero count of a 24-bit mantissa (valid for nonzero input)
	function automatic logic [LzW-1:0] lzc24(input logic [MantW-1:0] m);
		logic [LzW-1:0] n;
		logic           found;
		n = '0;
		found = 1'b0;
		for (int i = MantW - 1; i >= 0; i--) begin
			if (!found && m[i]) begin
				found = 1'b1;
				n = LzW'(MantW - 1 - i);
			end
		end
		return n;
	endfunction

endpackage

// ----- rtl/core/single_float_subtract.sv -----
// Top level: three-stage pipelined truncating single-precision subtractor.
// Each operand pair passes through the stage 1, stage 2 and stage 3 registers in turn.
// Throughput: one item per cycle while no stage stalls; stage 1 aligns (exponent compare and
// right shift), stage 2 adds or subtracts magnitudes, stage 3 normalizes.
// A stall holds every stage in place; a bubble is filled when the next stage frees.
// Reset (arst_n low) clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
module single_float_subtract (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] minuend_bits,
	input  logic [31:0] subtrahend_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] difference_bits
);
	localparam int unsigned PW = sfs_pkg::PipeW;

	// ---------------- Stage 1 logic: unpack, special cases, align
	sfs_pkg::align_t al_d;
	logic [7:0]  ea, eb, shift_amt;
	logic [22:0] fa, fb;
	logic [23:0] ma_full, mb_full;

	always_comb begin
		ea = minuend_bits[30:23];
		eb = subtrahend_bits[30:23];
		fa = minuend_bits[22:0];
		fb = subtrahend_bits[22:0];
		ma_full = {1'b1, fa};
		mb_full = {1'b1, fb};
		al_d = '0;
		al_d.sa = minuend_bits[31];
		al_d.sb = subtrahend_bits[31];
		al_d.add_op = minuend_bits[31] != subtrahend_bits[31];
		// zero operands pass straight through
		if (ea == '0 && fa == '0) begin
			al_d.bypass = 1'b1;
			al_d.bypass_word = {~subtrahend_bits[31], subtrahend_bits[30:0]};
		end else if (eb == '0 && fb == '0) begin
			al_d.bypass = 1'b1;
			al_d.bypass_word = minuend_bits;
		end
		if (ea < eb) begin
			shift_amt = eb - ea;
			al_d.er = eb;
			al_d.ma = (shift_amt >= 8'd24) ? '0 : (ma_full >> shift_amt[4:0]);
			al_d.mb = mb_full;
		end else begin
			shift_amt = ea - eb;
			al_d.er = ea;
			al_d.ma = ma_full;
			al_d.mb = (shift_amt >= 8'd24) ? '0 : (mb_full >> shift_amt[4:0]);
		end
	end

	logic          v1, r1;
	logic [PW-1:0] d1;
	sfs_pkg::align_t al_s1;

	sfs_pipe_reg u_s1 (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_data(PW'(al_d)),
		.out_valid(v1), .out_ready(r1), .out_data(d1)
	);
	assign al_s1 = sfs_pkg::align_t'(d1[$bits(sfs_pkg::align_t)-1:0]);

	// ---------------- Stage 2 logic: magnitude add or subtract
	sfs_pkg::sum_t sm_d;

	always_comb begin
		sm_d = '0;
		sm_d.bypass = al_s1.bypass;
		sm_d.bypass_word = al_s1.bypass_word;
		sm_d.add_op = al_s1.add_op;
		sm_d.er = al_s1.er;
		if (al_s1.add_op) begin
			sm_d.mr = {1'b0, al_s1.ma} + {1'b0, al_s1.mb};
			sm_d.sr = al_s1.sa;
		end else if (al_s1.ma >= al_s1.mb) begin
			sm_d.mr = {1'b0, al_s1.ma - al_s1.mb};
			sm_d.sr = al_s1.sa;
		end else begin
			sm_d.mr = {1'b0, al_s1.mb - al_s1.ma};
			sm_d.sr = ~al_s1.sb;
		end
	end

	logic          v2, r2;
	logic [PW-1:0] d2;
	sfs_pkg::sum_t sm_s2;

	sfs_pipe_reg u_s2 (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v1), .in_ready(r1),
		.in_data(PW'(sm_d)),
		.out_valid(v2), .out_ready(r2), .out_data(d2)
	);
	assign sm_s2 = sfs_pkg::sum_t'(d2[$bits(sfs_pkg::sum_t)-1:0]);

	// ---------------- Stage 3 logic: normalize, saturate, flush, pack
	logic [31:0] res_d;
	logic [4:0]  lz;
	logic [23:0] mn;
	logic [8:0]  er_inc;

	always_comb begin
		lz = sfs_pkg::lzc24(sm_s2.mr[23:0]);
		mn = sm_s2.mr[23:0] << lz;
		er_inc = {1'b0, sm_s2.er} + 9'd1;
		if (sm_s2.bypass) begin
			res_d = sm_s2.bypass_word;
		end else if (sm_s2.add_op) begin
			if (sm_s2.mr[24]) begin
				if (er_inc[8]) res_d = {sm_s2.sr, sfs_pkg::ExpMax, 23'd0};
				else res_d = {sm_s2.sr, er_inc[7:0], sm_s2.mr[23:1]};
			end else begin
				res_d = {sm_s2.sr, sm_s2.er, sm_s2.mr[22:0]};
			end
		end else if (sm_s2.mr == '0) begin
			res_d = '0;  // exact cancellation gives +0
		end else if ({3'b0, lz} > sm_s2.er) begin
			res_d = {sm_s2.sr, 31'd0};  // underflow flushes to signed zero
		end else begin
			res_d = {sm_s2.sr, sm_s2.er - {3'b0, lz}, mn[22:0]};
		end
	end

	logic [PW-1:0] d3;

	sfs_pipe_reg u_s3 (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v2), .in_ready(r2),
		.in_data(PW'(res_d)),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(d3)
	);
	assign difference_bits = d3[31:0];

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(difference_bits))
		else $error("result changed while stalled");
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v2 && !r2 |=> v2)
		else $error("stage 2 item lost during stall");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v1 && !r1 |=> v1)
		else $error("stage 1 item lost during stall");
`endif
endmodule

// ----- rtl/core/sfs_pipe_reg.sv -----
// Module: one elastic pipeline register stage with valid bit and stall hold.
`timescale 1ns / 1ps
module sfs_pipe_reg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [sfs_pkg::PipeW-1:0]  in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [sfs_pkg::PipeW-1:0]  out_data
);
	logic                      valid_q;
	logic [sfs_pkg::PipeW-1:0] data_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= in_data;
		end
	end
endmodule

// ----- bench/single_float_subtract_checker.sv -----
// Checker: watches both channels, predicts each difference and compares it with the result.
`timescale 1ns / 1ps
module single_float_subtract_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] minuend_bits,
	input  logic [31:0] subtrahend_bits,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] difference_bits,
	output int          fail_count,
	output int          pending_count,
	output int          result_count
);
	logic [31:0] pending_diffs[$];

	function automatic logic [31:0] predict_difference(input logic [31:0] a, input logic [31:0] b);
		logic        sa, sb, sr;
		logic [7:0]  ea, eb;
		logic [23:0] ma, mb;
		logic [24:0] mr;
		int          er;
		sa = a[31];
		sb = b[31];
		ea = a[30:23];
		eb = b[30:23];
		if (a[30:0] == '0)
			return b ^ 32'h8000_0000;
		if (b[30:0] == '0)
			return a;
		ma = {1'b1, a[22:0]};
		mb = {1'b1, b[22:0]};
		if (ea < eb) begin
			ma = (eb - ea >= 24) ? '0 : ma >> (eb - ea);
			er = eb;
		end else begin
			mb = (ea - eb >= 24) ? '0 : mb >> (ea - eb);
			er = ea;
		end
		if (sa != sb) begin
			mr = ma + mb;
			sr = sa;
			if (mr[24]) begin
				mr = mr >> 1;
				er++;
			end
			if (er > 255)
				return {sr, 8'hFF, 23'h0};
		end else begin
			if (ma >= mb) begin
				mr = ma - mb;
				sr = sa;
			end else begin
				mr = mb - ma;
				sr = ~sb;
			end
			if (mr == '0)
				return '0;
			while (!mr[23]) begin
				mr = mr << 1;
				er--;
			end
			if (er < 0)
				return {sr, 31'h0};
		end
		return {sr, er[7:0], mr[22:0]};
	endfunction

	assign pending_count = pending_diffs.size();

	always @(posedge clk) begin
		logic [31:0] want;
		if (!arst_n) begin
			fail_count <= 0;
			result_count <= 0;
		end else begin
			if (in_valid && in_ready)
				pending_diffs.push_back(predict_difference(minuend_bits, subtrahend_bits));
			if (out_valid && out_ready) begin
				result_count <= result_count + 1;
				if (pending_diffs.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result %h", difference_bits);
					fail_count <= fail_count + 1;
				end else begin
					want = pending_diffs.pop_front();
					if (want !== difference_bits) begin
						if (fail_count < 10)
							$display("mismatch: expected %h got %h", want, difference_bits);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ----- bench/single_float_subtract_tb.sv -----
// Testbench top: drives operand pairs with random gaps and gives the verdict.
`timescale 1ns / 1ps
module single_float_subtract_tb;
	localparam int WatchdogLimit = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] minuend_bits = '0;
	logic [31:0] subtrahend_bits = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] difference_bits;
	int          fail_count, pending_count, result_count;
	int          idle_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	single_float_subtract dut (.*);

	single_float_subtract_checker checker_i (.*);

	// mostly short gaps, an occasional long one
	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(5, 40);
		return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0;
	endfunction

	// operand with random sign, exponent and fraction; sometimes extremes
	function automatic logic [31:0] rand_word();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(0, 7))
			0: w[30:0] = '0;
			1: w[30:23] = 8'hFF;
			2: w[30:23] = 8'h00;
			3: w[22:0] = $urandom_range(0, 1) ? 23'h7FFFFF : 23'h0;
			default: ;
		endcase
		return w;
	endfunction

	// present one item and hold it until accepted; valid drops only for a gap
	task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
		int g;
		bit acc;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		minuend_bits <= a;
		subtrahend_bits <= b;
		// ready is stable from the falling edge to the next rising edge
		forever begin
			@(negedge clk);
			acc = in_ready;
			@(posedge clk);
			if (acc) break;
		end
	endtask

	// random receiver stalls; with bursts of always-ready
	always @(posedge clk) begin
		if ($urandom_range(0, 3) == 0)
			out_ready <= ($urandom_range(0, 9) < 3) ? 1'b0 : 1'b1;
	end

	// watchdog: cycles with no accept on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("watchdog timeout");
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		logic [31:0] a, b;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: zeros, sign flips, cancellation, overflow, underflow, big shift
		send_pair(32'h0000_0000, 32'h3F80_0000);
		send_pair(32'h8000_0000, 32'hBF80_0000);
		send_pair(32'h3F80_0000, 32'h0000_0000);
		send_pair(32'h3F80_0000, 32'h8000_0000);
		send_pair(32'h0000_0000, 32'h0000_0000);
		send_pair(32'h3F80_0000, 32'h3F80_0000);
		send_pair(32'hC0A0_0000, 32'hC0A0_0000);
		send_pair(32'h7F7F_FFFF, 32'hFF7F_FFFF);
		send_pair(32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_pair(32'h0000_0001, 32'h0000_0002);
		send_pair(32'h0080_0000, 32'h0080_0001);
		send_pair(32'h4B80_0000, 32'h3F80_0000);
		send_pair(32'h3F80_0000, 32'h4C00_0000);
		send_pair(32'h3F80_0000, 32'h3F7F_FFFF);
		send_pair(32'h3F7F_FFFF, 32'h3F80_0000);
		send_pair(32'h4000_0000, 32'hBF80_0000);
		send_pair(32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_pair(32'h0000_0000, 32'hFFFF_FFFF);
		send_pair(32'h4B00_0000, 32'h3F80_0000);
		// drain completely before the random phase
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		for (int i = 0; i < 900; i++) begin
			a = rand_word();
			case ($urandom_range(0, 5))
				0: b = a;
				1: b = {~a[31], a[30:0]};
				2: b = {a[31:23] + 9'($urandom_range(0, 2)), 23'($urandom)};
				default: b = rand_word();
			endcase
			if ($urandom_range(0, 1))
				send_pair(a, b);
			else
				send_pair(b, a);
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Checked %0d differences: zero operands, cancellation, overflow,", result_count);
		$display("underflow, large alignment shifts and random operands with stalls.");
		if (fail_count == 0 && pending_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/core/sfs_pkg.sv
rtl/core/sfs_pipe_reg.sv
rtl/core/single_float_subtract.sv
bench/single_float_subtract_checker.sv
bench/single_float_subtract_tb.sv
